FILE: rtl/tcl_pkg.sv
// ============================================================================
// tcl_pkg
// Shared types and constants of the trie child lookup core: table sizes,
// command and status codes, memory port bundles and the result word.
// ============================================================================
`default_nettype none

package tcl_pkg;

    // table geometry
    localparam int MAX_NODES    = 4096;
    localparam int TOKEN_BITS   = 16;
    localparam int OFFSET_DEPTH = MAX_NODES + 1;
    localparam int EDGE_DEPTH   = MAX_NODES - 1;
    localparam int OFF_AW       = $clog2(OFFSET_DEPTH);
    localparam int EDGE_AW      = $clog2(EDGE_DEPTH);

    // field widths
    localparam int ENTRY_W  = 12;
    localparam int CMD_W    = 2;
    localparam int INDEX_W  = 13;
    localparam int VALUE_W  = 16;
    localparam int STATE_W  = 12;
    localparam int TOKEN_W  = 16;
    localparam int STATUS_W = 2;
    localparam int NCOUNT_W = 13;
    localparam int TCOUNT_W = 16;
    localparam int CFG_IW   = 1;
    localparam int CFG_DW   = 16;

    // command codes
    localparam logic [CMD_W-1:0] CMD_WR_OFFSET = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WR_EDGE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP    = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_NODE_COUNT  = 1'b0;
    localparam logic [CFG_IW-1:0] CFG_TOKEN_COUNT = 1'b1;

    // controller phases
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_BEGIN,
        PH_END,
        PH_SEARCH
    } phase_t;

    typedef struct packed {
        logic [NCOUNT_W-1:0] node_count;
        logic [TCOUNT_W-1:0] token_count;
    } cfg_t;

    typedef struct packed {
        logic              we;
        logic [OFF_AW-1:0] addr;
        logic [ENTRY_W-1:0] wdata;
    } off_port_t;

    typedef struct packed {
        logic                 we;
        logic [EDGE_AW-1:0]   addr;
        logic [TOKEN_BITS-1:0] wdata;
    } edge_port_t;

    typedef struct packed {
        logic                done;
        logic [STATUS_W-1:0] status;
        logic [STATE_W-1:0]  child_state;
        logic                has_children;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/tcl_ram.sv
// ============================================================================
// tcl_ram
// Generic single-port synchronous RAM, write and registered read on one
// address, read data in the cycle after the address.
// ============================================================================
`default_nettype none

module tcl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/tcl_ctrl.sv
// ============================================================================
// tcl_ctrl
// Command sequencer: table writes, the two offset reads and the bisection
// over the edge token memory, one probe per cycle, plus the result register.
// ============================================================================
`default_nettype none

module tcl_ctrl
    import tcl_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [CMD_W-1:0]      command,
    input  wire logic [INDEX_W-1:0]    index,
    input  wire logic [VALUE_W-1:0]    value,
    input  wire logic [STATE_W-1:0]    state,
    input  wire logic                  state_is_invalid,
    input  wire logic [TOKEN_W-1:0]    token,
    input  wire cfg_t                  cfg,
    input  wire logic [ENTRY_W-1:0]    off_rdata,
    input  wire logic [TOKEN_BITS-1:0] edge_rdata,
    output off_port_t                  off_port,
    output edge_port_t                 edge_port,
    output logic                       busy,
    output result_t                    result
);

    phase_t phase_reg, phase_next;

    logic [STATE_W-1:0]    node_reg;
    logic [TOKEN_BITS-1:0] token_reg;
    logic                  token_ok_reg;
    logic [ENTRY_W-1:0]    begin_reg, begin_next;
    logic [ENTRY_W-1:0]    lo_reg, lo_next;
    logic [ENTRY_W-1:0]    hi_reg, hi_next;
    logic [ENTRY_W-1:0]    mid_reg, mid_next;
    logic                  hit_reg, hit_next;
    logic                  match_reg, match_next;
    logic                  has_reg, has_next;
    result_t               res_reg, res_next;

    logic                  accept;
    logic                  is_lookup;
    logic                  token_ok;
    logic                  state_ok;
    logic                  lookup_go;
    logic [ENTRY_W-1:0]    end_c;
    logic                  end_has;
    logic                  range_empty;
    logic [ENTRY_W-1:0]    first_mid;
    logic                  probe_below;
    logic [ENTRY_W-1:0]    s_lo, s_hi, s_mid;
    logic                  s_hit, s_match;
    logic                  search_more;

    // decode of the accepted word
    assign accept    = start && (phase_reg == PH_IDLE);
    assign busy      = (phase_reg != PH_IDLE);
    assign is_lookup = (command == CMD_LOOKUP);
    assign token_ok  = (token < cfg.token_count);
    assign state_ok  = ({1'b0, state} < cfg.node_count)
                       && ({1'b0, state} < NCOUNT_W'(MAX_NODES));
    assign lookup_go = accept && is_lookup && !state_is_invalid && state_ok;

    // range setup once both offsets are in
    always_comb
    begin
        end_c       = (off_rdata > ENTRY_W'(EDGE_DEPTH)) ? ENTRY_W'(EDGE_DEPTH) : off_rdata;
        end_has     = (begin_reg != off_rdata);
        range_empty = !token_ok_reg || (end_c <= begin_reg);
        first_mid   = begin_reg + ((end_c - begin_reg) >> 1);
    end

    // one bisection step on the token that just came back
    always_comb
    begin
        probe_below = (edge_rdata < token_reg);
        if (probe_below)
        begin
            s_lo    = ENTRY_W'(mid_reg + 1'b1);
            s_hi    = hi_reg;
            s_hit   = hit_reg;
            s_match = match_reg;
        end
        else
        begin
            s_lo    = lo_reg;
            s_hi    = mid_reg;
            s_hit   = 1'b1;
            s_match = (edge_rdata == token_reg);
        end
        s_mid       = s_lo + ((s_hi - s_lo) >> 1);
        search_more = (s_lo < s_hi);
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (lookup_go)
                begin
                    phase_next = PH_BEGIN;
                end
            end
            PH_BEGIN:
            begin
                phase_next = PH_END;
            end
            PH_END:
            begin
                phase_next = range_empty ? PH_IDLE : PH_SEARCH;
            end
            PH_SEARCH:
            begin
                phase_next = search_more ? PH_SEARCH : PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // memory ports, search registers and result word
    always_comb
    begin
        off_port.we     = 1'b0;
        off_port.addr   = {1'b0, state};
        off_port.wdata  = value[ENTRY_W-1:0];
        edge_port.we    = 1'b0;
        edge_port.addr  = mid_reg;
        edge_port.wdata = value[TOKEN_BITS-1:0];
        begin_next      = begin_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        hit_next        = hit_reg;
        match_next      = match_reg;
        has_next        = has_reg;
        res_next        = '0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (accept)
                begin
                    if (command == CMD_WR_OFFSET)
                    begin
                        off_port.we   = ({1'b0, index} < (INDEX_W+1)'(OFFSET_DEPTH));
                        off_port.addr = OFF_AW'(index);
                    end
                    else if (command == CMD_WR_EDGE)
                    begin
                        edge_port.we   = ({1'b0, index} < (INDEX_W+1)'(EDGE_DEPTH));
                        edge_port.addr = index[EDGE_AW-1:0];
                    end
                    // words that end before any table read: writes, unused commands and rejected lookups
                    if (!is_lookup)
                    begin
                        res_next.done   = 1'b1;
                        res_next.status = ST_OK;
                    end
                    else if (state_is_invalid)
                    begin
                        res_next.done   = 1'b1;
                        res_next.status = ST_MISS;
                    end
                    else if (!state_ok)
                    begin
                        res_next.done   = 1'b1;
                        res_next.status = token_ok ? ST_RANGE : ST_MISS;
                    end
                end
            end
            PH_BEGIN:
            begin
                off_port.addr = OFF_AW'({1'b0, node_reg} + 1'b1);
                begin_next    = off_rdata;
            end
            PH_END:
            begin
                has_next = end_has;
                if (range_empty)
                begin
                    res_next.done         = 1'b1;
                    res_next.status       = ST_MISS;
                    res_next.has_children = end_has;
                end
                else
                begin
                    lo_next        = begin_reg;
                    hi_next        = end_c;
                    mid_next       = first_mid;
                    hit_next       = 1'b0;
                    match_next     = 1'b0;
                    edge_port.addr = first_mid;
                end
            end
            PH_SEARCH:
            begin
                lo_next        = s_lo;
                hi_next        = s_hi;
                mid_next       = s_mid;
                hit_next       = s_hit;
                match_next     = s_match;
                edge_port.addr = s_mid;
                if (!search_more)
                begin
                    // lo meets hi: a hit on the last lowered bound decides
                    res_next.done         = 1'b1;
                    res_next.has_children = has_reg;
                    if (s_hit && s_match)
                    begin
                        res_next.status      = ST_OK;
                        res_next.child_state = STATE_W'(s_lo + 1'b1);
                    end
                    else
                    begin
                        res_next.status = ST_MISS;
                    end
                end
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    // control state and result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            res_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            res_reg   <= res_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (lookup_go)
        begin
            node_reg     <= state;
            token_reg    <= token[TOKEN_BITS-1:0];
            token_ok_reg <= token_ok;
        end
        begin_reg <= begin_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        hit_reg   <= hit_next;
        match_reg <= match_next;
        has_reg   <= has_next;
    end

    assign result = res_reg;

    // bisection bounds stay ordered while probing
    a_bounds_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SEARCH) |-> (lo_reg < hi_reg))
        else $error("search bounds crossed");

    // probing ends only with a result word
    a_search_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SEARCH) |=> (phase_reg == PH_SEARCH) || res_reg.done)
        else $error("search left without a result");

    // a found child is never node zero
    a_child_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_reg.done && res_reg.status == ST_OK && res_reg.has_children)
        |-> (res_reg.child_state != '0))
        else $error("found child is zero");

    // a found edge implies the node has edges
    a_found_has: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(phase_reg) == PH_SEARCH && res_reg.done && res_reg.status == ST_OK)
        |-> res_reg.has_children)
        else $error("found edge on a childless node");

endmodule

`default_nettype wire

FILE: rtl/trie_child_lookup_core.sv
// ============================================================================
// trie_child_lookup_core
// Trie transition engine over a compressed row table: offset and edge token
// memories, loaded by write words and searched by lookup words.
// ============================================================================
//
//  channel   handshake            payload
//  --------  -------------------  ------------------------------------------
//  command   start, busy          command, index, value, state,
//                                 state_is_invalid, token
//  result    done (one cycle)     status, child_state, has_children
//  config    cfg_write            cfg_index, cfg_data
//
//  A write word (or unused command) is taken only while idle; its result shows
//  in the next cycle and busy stays low.
//  A lookup makes the two offset reads through the single offset memory
//  port, then probes the edge token memory, ceil(log2(range+1)) probes, at
//  most 12; the result word is registered after the last probe. Lookups
//  that fail on the marker or the state range answer in the next cycle.
//  Reset clears the sequencer and sets node_count and token_count to 1; the
//  tables are not cleared. Results cannot be stalled.
//
`default_nettype none

module trie_child_lookup_core
    import tcl_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [CMD_W-1:0]    command,
    input  wire logic [INDEX_W-1:0]  index,
    input  wire logic [VALUE_W-1:0]  value,
    input  wire logic [STATE_W-1:0]  state,
    input  wire logic                state_is_invalid,
    input  wire logic [TOKEN_W-1:0]  token,
    output logic                     done,
    output logic [STATUS_W-1:0]      status,
    output logic [STATE_W-1:0]       child_state,
    output logic                     has_children,
    input  wire logic                cfg_write,
    input  wire logic [CFG_IW-1:0]   cfg_index,
    input  wire logic [CFG_DW-1:0]   cfg_data
);

    cfg_t                  cfg_reg;
    off_port_t             off_port;
    edge_port_t            edge_port;
    logic [ENTRY_W-1:0]    off_rdata;
    logic [TOKEN_BITS-1:0] edge_rdata;
    result_t               result;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.node_count  <= NCOUNT_W'(1);
            cfg_reg.token_count <= TCOUNT_W'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_NODE_COUNT:
                begin
                    cfg_reg.node_count <= cfg_data[NCOUNT_W-1:0];
                end
                CFG_TOKEN_COUNT:
                begin
                    cfg_reg.token_count <= cfg_data[TCOUNT_W-1:0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    // per-node edge offsets
    tcl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (OFFSET_DEPTH)
    ) u_offset_ram (
        .clk   (clk),
        .we    (off_port.we),
        .addr  (off_port.addr),
        .wdata (off_port.wdata),
        .rdata (off_rdata)
    );

    // edge tokens
    tcl_ram #(
        .WIDTH (TOKEN_BITS),
        .DEPTH (EDGE_DEPTH)
    ) u_edge_ram (
        .clk   (clk),
        .we    (edge_port.we),
        .addr  (edge_port.addr),
        .wdata (edge_port.wdata),
        .rdata (edge_rdata)
    );

    // sequencer and search
    tcl_ctrl u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .command          (command),
        .index            (index),
        .value            (value),
        .state            (state),
        .state_is_invalid (state_is_invalid),
        .token            (token),
        .cfg              (cfg_reg),
        .off_rdata        (off_rdata),
        .edge_rdata       (edge_rdata),
        .off_port         (off_port),
        .edge_port        (edge_port),
        .busy             (busy),
        .result           (result)
    );

    assign done         = result.done;
    assign status       = result.status;
    assign child_state  = result.child_state;
    assign has_children = result.has_children;

endmodule

`default_nettype wire
